@@ rtl/core/tmcw_pkg.sv @@
// Package for the text-mode console writer: item structs, control codes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
`default_nettype none

package tmcw_pkg;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Width of the cursor position and cell index fields
	localparam int POS_W = 11;

	// Action codes
	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Character codes
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7F;
	localparam logic [7:0] SPACE_CODE  = 8'h20;

	localparam int TAB_STEP = 8;

	// Attribute after reset, and the blank cell the reset sweep writes
	localparam logic [7:0]  RESET_ATTR  = 8'h0F;
	localparam logic [15:0] RESET_BLANK = {RESET_ATTR, SPACE_CODE};

	typedef struct packed {
		logic [1:0]       action;
		logic [7:0]       char_code;
		logic [POS_W-1:0] cell_index;
	} tmcw_in_t;

	typedef struct packed {
		logic [POS_W-1:0] cursor_position;
		logic [15:0]      cell_word;
		logic             scrolled;
	} tmcw_out_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FILL,
		ST_SHIFT,
		ST_BLANK,
		ST_RESULT
	} state_t;

	// Store operation for the current cycle
	typedef enum logic [1:0] {
		OP_NONE,
		OP_INIT,
		OP_BLANK,
		OP_SHIFT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   accept;
		logic   cnt_clr;
		logic   cnt_inc;
		logic   load;
	} ctl_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic shift_end;
		logic put_scroll;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/text_mode_console_writer_top.sv @@
// Put/read: result registered when the output is free; next item taken only after the load.
// Put that scrolls: row copy then last-row blanking, one cell a cycle.
// Clear: blanks one cell a cycle through the store's write port.
// After reset a sweep writes blank cells to the whole store; cmd_stall stays high meanwhile,
// while attribute writes are taken at once. Attribute resets to 0x0F, cursor to 0,0.
// Top level of the text-mode console writer; depends on tmcw_pkg, tmcw_ctrl, tmcw_dp.
`default_nettype none

module text_mode_console_writer_top #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire tmcw_pkg::tmcw_in_t  cmd,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output tmcw_pkg::tmcw_out_t      rsp,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_data
);
	import tmcw_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// Attribute writes are always taken
	assign cfg_ready = 1'b1;

	tmcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_valid),
		.action   (cmd.action),
		.stat     (stat),
		.cmd      (ctl),
		.in_stall (cmd_stall)
	);

	tmcw_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (cmd),
		.cmd       (ctl),
		.stat      (stat),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ rtl/core/tmcw_ctrl.sv @@
// Controller state machine of the text-mode console writer: sequences the
// reset sweep, clear, scroll and result hand-off. Depends on tmcw_pkg.
`default_nettype none

module tmcw_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [1:0]       action,
	input  wire tmcw_pkg::dp_stat_t stat,
	output tmcw_pkg::ctl_cmd_t    cmd,
	output logic                  in_stall
);
	import tmcw_pkg::*;

	state_t state_q, state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		unique case (state_q)
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (stat.cnt_last) begin
					state_n = ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept  = 1'b1;
					cmd.cnt_clr = 1'b1;
					unique case (action)
						ACT_PUT:   state_n = stat.put_scroll ? ST_SHIFT : ST_RESULT;
						ACT_CLEAR: state_n = ST_FILL;
						default:   state_n = ST_RESULT;
					endcase
				end
			end
			ST_FILL: begin
				cmd.op = OP_BLANK;
				if (stat.cnt_last) begin
					state_n = ST_RESULT;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_SHIFT: begin
				cmd.op = OP_SHIFT;
				if (stat.shift_end) begin
					state_n = ST_BLANK;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_BLANK: begin
				cmd.op = OP_BLANK;
				if (stat.cnt_last) begin
					state_n = ST_RESULT;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_RESULT: begin
				if (!stat.out_busy) begin
					cmd.load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Take items only between operations
	assign in_stall = (state_q != ST_IDLE);

`ifndef SYNTH
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while the previous one is in progress");

	a_shift_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT && !stat.shift_end |=> state_q == ST_SHIFT)
		else $error("scroll copy left before its end");

	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_IDLE && !in_stall)
		else $error("result loaded without returning to idle");
`endif

endmodule

`default_nettype wire

@@ rtl/core/tmcw_dp.sv @@
// Datapath of the text-mode console writer: cursor, attribute register, cell
// store, sweep counter and result register. Depends on tmcw_pkg.
`default_nettype none

module tmcw_dp #(
	parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tmcw_pkg::tmcw_in_t in_data,
	input  wire tmcw_pkg::ctl_cmd_t cmd,
	output tmcw_pkg::dp_stat_t      stat,
	input  wire logic               cfg_valid,
	input  wire logic [7:0]         cfg_data,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output tmcw_pkg::tmcw_out_t     rsp
);
	import tmcw_pkg::*;

	localparam int N   = COLUMNS * ROWS;
	localparam int AW  = $clog2(N);
	localparam int CW  = $clog2(COLUMNS);
	localparam int CXW = $clog2(COLUMNS + TAB_STEP);
	localparam int RW  = $clog2(ROWS);
	localparam int PW  = (AW > POS_W) ? AW : POS_W;

	logic [7:0]    attr_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] cnt_q;
	logic          read_q;
	logic          inrange_q;
	logic          scrolled_q;
	logic          rsp_valid_q;
	tmcw_out_t     rsp_q;

	logic [15:0]   mem_q [N];
	logic [15:0]   rdata_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;
	logic [AW-1:0] raddr;

	logic [AW-1:0]  lin;
	logic [PW-1:0]  idx_ext;
	logic [CXW-1:0] col_x;
	logic [RW:0]    row_x;
	logic [RW-1:0]  row_n;
	logic           row_inc;
	logic           printable;
	logic           put_scroll;

	// Linear cursor location
	assign lin     = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);
	assign idx_ext = PW'(in_data.cell_index);

	assign printable = (in_data.char_code >= CH_PRINT_LO) &&
		(in_data.char_code <= CH_PRINT_HI);

	// Next cursor for a put
	always_comb begin
		col_x   = CXW'(col_q);
		row_inc = 1'b0;
		priority if (in_data.char_code == CH_BS && col_q != '0) begin
			col_x = CXW'(col_q) - CXW'(1);
		end else if (in_data.char_code == CH_TAB) begin
			col_x = (CXW'(col_q) + CXW'(TAB_STEP)) & ~CXW'(TAB_STEP - 1);
		end else if (in_data.char_code == CH_CR) begin
			col_x = '0;
		end else if (in_data.char_code == CH_LF) begin
			col_x   = '0;
			row_inc = 1'b1;
		end else if (printable) begin
			col_x = CXW'(col_q) + CXW'(1);
		end else begin
			col_x = CXW'(col_q);
		end
		// wrap at the right edge
		if (col_x >= CXW'(COLUMNS)) begin
			col_x   = '0;
			row_inc = 1'b1;
		end
		row_x      = (RW+1)'(row_q) + (RW+1)'(row_inc);
		put_scroll = (row_x >= (RW+1)'(ROWS));
		row_n      = put_scroll ? RW'(ROWS - 1) : row_x[RW-1:0];
	end

	// Status to the controller
	always_comb begin
		stat            = '0;
		stat.cnt_last   = (cnt_q == AW'(N - 1));
		stat.shift_end  = (cnt_q == AW'(N - COLUMNS));
		stat.put_scroll = put_scroll;
		stat.out_busy   = rsp_valid_q && rsp_stall;
	end

	// Store port selection
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q;
		wdata = {attr_q, SPACE_CODE};
		re    = 1'b0;
		raddr = cnt_q;
		priority if (cmd.op == OP_INIT) begin
			we    = 1'b1;
			wdata = RESET_BLANK;
		end else if (cmd.op == OP_BLANK) begin
			we = 1'b1;
		end else if (cmd.op == OP_SHIFT) begin
			// read one row ahead, write the word read last cycle one cell back
			re    = !stat.shift_end;
			raddr = cnt_q + AW'(COLUMNS);
			we    = (cnt_q != '0);
			waddr = cnt_q - AW'(1);
			wdata = rdata_q;
		end else if (cmd.accept && in_data.action == ACT_PUT) begin
			we    = printable;
			waddr = lin;
			wdata = {attr_q, in_data.char_code};
		end else if (cmd.accept && in_data.action == ACT_READ) begin
			re    = 1'b1;
			raddr = idx_ext[AW-1:0];
		end else begin
			we = 1'b0;
		end
	end

	// Cell store
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid) begin
			attr_q <= cfg_data;
		end
	end

	// Sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Cursor and per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			read_q     <= 1'b0;
			inrange_q  <= 1'b0;
			scrolled_q <= 1'b0;
		end else if (cmd.accept) begin
			read_q     <= (in_data.action == ACT_READ);
			inrange_q  <= (idx_ext < PW'(N));
			scrolled_q <= (in_data.action == ACT_PUT) && put_scroll;
			if (in_data.action == ACT_PUT) begin
				col_q <= col_x[CW-1:0];
				row_q <= row_n;
			end else if (in_data.action == ACT_CLEAR) begin
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.cursor_position <= POS_W'(lin);
			rsp_q.cell_word       <= (read_q && inrange_q) ? rdata_q : 16'h0000;
			rsp_q.scrolled        <= scrolled_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> ({1'b0, waddr} < (AW+1)'(N)))
		else $error("store write outside the screen");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(rsp_valid_q && rsp_stall))
		else $error("result overwritten while still held");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> ((RW+1)'(row_q) < (RW+1)'(ROWS)) &&
			((CW+1)'(col_q) < (CW+1)'(COLUMNS)))
		else $error("cursor left the screen");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for text_mode_console_writer_top: random and directed
// console actions, a class mirror of screen store and cursor, per-field result checks.
// Depends on tmcw_pkg and the RTL of text_mode_console_writer_top.

module tb_top;
	import tmcw_pkg::*;

	localparam int N_COLS   = COLUMNS_DEF;
	localparam int N_ROWS   = ROWS_DEF;
	localparam int N_CELLS  = N_COLS * N_ROWS;
	localparam int IDX_MAX  = (1 << POS_W) - 1;

	// Action code the block leaves unused
	localparam logic [1:0] ACT_NOP = 2'd3;

	localparam int N_PHASES     = 7;
	localparam int PHASE_ITEMS  = 190;
	localparam int N_DIRECTED   = 20;
	localparam int MAX_GAP      = 60;
	localparam int MAX_STALL    = 60;
	localparam int HOLDOFF      = 600;
	localparam int HOLDOFF_AT   = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int N_ITEMS      = N_DIRECTED + N_PHASES * PHASE_ITEMS;
	localparam int LIMIT = N_CELLS + HOLDOFF
		+ 3 * (N_ITEMS * (N_CELLS + 3 + MAX_GAP + MAX_STALL) + N_PHASES * 100);

	// Mirror of the screen store and cursor; holds the results still due
	class console_mirror;
		logic [15:0] cells [N_CELLS];
		int          col;
		int          row;
		logic [7:0]  attr;
		tmcw_out_t   due_results [$];
		int          errors;

		function new();
			attr   = RESET_ATTR;
			col    = 0;
			row    = 0;
			errors = 0;
			foreach (cells[i]) cells[i] = RESET_BLANK;
		endfunction

		function void set_attr(logic [7:0] v);
			attr = v;
		endfunction

		function int cursor();
			return row * N_COLS + col;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void blank_range(int from, int upto);
			for (int i = from; i < upto; i++) cells[i] = {attr, SPACE_CODE};
		endfunction

		// Apply one put byte; return 1 when the screen scrolled
		function logic put_byte(logic [7:0] ch);
			if (ch == CH_BS && col != 0) begin
				col--;
			end else if (ch == CH_TAB) begin
				col = (col + TAB_STEP) & ~(TAB_STEP - 1);
			end else if (ch == CH_CR) begin
				col = 0;
			end else if (ch == CH_LF) begin
				col = 0;
				row++;
			end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
				cells[row * N_COLS + col] = {attr, ch};
				col++;
			end
			if (col >= N_COLS) begin
				col = 0;
				row++;
			end
			if (row < N_ROWS) return 1'b0;
			for (int i = 0; i < N_CELLS - N_COLS; i++) cells[i] = cells[i + N_COLS];
			blank_range(N_CELLS - N_COLS, N_CELLS);
			row = N_ROWS - 1;
			return 1'b1;
		endfunction

		// Note an accepted item and queue the result it causes
		function void note_cmd(tmcw_in_t c);
			tmcw_out_t r;
			r = '0;
			case (c.action)
				ACT_PUT: begin
					r.scrolled = put_byte(c.char_code);
				end
				ACT_CLEAR: begin
					blank_range(0, N_CELLS);
					col = 0;
					row = 0;
				end
				ACT_READ: begin
					if (c.cell_index < N_CELLS) r.cell_word = cells[c.cell_index];
				end
				default: ;
			endcase
			r.cursor_position = POS_W'(cursor());
			due_results.push_back(r);
		endfunction

		// Compare one accepted result with the oldest one due
		function void check_result(tmcw_out_t got);
			tmcw_out_t want;
			if (due_results.size() == 0) begin
				$error("result with no item pending: cursor_position %0d", got.cursor_position);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.cursor_position !== want.cursor_position) begin
				$error("cursor_position: expected %0d, actual %0d",
					want.cursor_position, got.cursor_position);
				errors++;
			end
			if (got.cell_word !== want.cell_word) begin
				$error("cell_word: expected 0x%04h, actual 0x%04h",
					want.cell_word, got.cell_word);
				errors++;
			end
			if (got.scrolled !== want.scrolled) begin
				$error("scrolled: expected %0b, actual %0b", want.scrolled, got.scrolled);
				errors++;
			end
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	tmcw_in_t   cmd       = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	tmcw_out_t  rsp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = '0;

	console_mirror mirror;
	int            cycles = 0;

	text_mode_console_writer_top #(
		.COLUMNS(N_COLS),
		.ROWS   (N_ROWS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		while (cycles < LIMIT) @(posedge clk) cycles++;
		$display("status: fail");
		$finish;
	end

	function automatic tmcw_in_t make_cmd(logic [1:0] a, logic [7:0] ch, int idx);
		tmcw_in_t c;
		c.action     = a;
		c.char_code  = ch;
		c.cell_index = POS_W'(idx);
		return c;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(16, MAX_GAP);
	endfunction

	// Pick a byte that is neither printable nor a control the block obeys
	function automatic logic [7:0] ignored_byte();
		logic [7:0] v;
		if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h80, 8'hFF));
		v = 8'($urandom_range(0, 31));
		if (v == CH_BS || v == CH_TAB || v == CH_LF || v == CH_CR) v = v ^ 8'h10;
		return v;
	endfunction

	// Random action; long lines favor wrapping at the right edge over line feeds
	function automatic tmcw_in_t random_cmd(bit long_lines);
		tmcw_in_t c;
		int r;
		int k;
		int near;
		c.action     = ACT_PUT;
		c.char_code  = 8'($urandom_range(0, 255));
		c.cell_index = POS_W'($urandom_range(0, IDX_MAX));
		r = $urandom_range(0, 999);
		if (r < 5) begin
			c.action = ACT_CLEAR;
		end else if (r < 20) begin
			c.action = ACT_NOP;
		end else if (r < 220) begin
			c.action = ACT_READ;
			k = $urandom_range(0, 9);
			if (k == 0) begin
				c.cell_index = POS_W'($urandom_range(N_CELLS, IDX_MAX));
			end else if (k < 5) begin
				c.cell_index = POS_W'($urandom_range(0, N_CELLS - 1));
			end else begin
				near = mirror.cursor() - $urandom_range(0, 2 * N_COLS);
				if (near < 0) near = $urandom_range(0, N_COLS - 1);
				c.cell_index = POS_W'(near);
			end
		end else begin
			k = $urandom_range(0, 99);
			if (long_lines) begin
				if (k < 80)      c.char_code = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
				else if (k < 90) c.char_code = CH_TAB;
				else if (k < 94) c.char_code = CH_BS;
				else if (k < 97) c.char_code = ignored_byte();
				else             c.char_code = CH_CR;
			end else begin
				if (k < 58)      c.char_code = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
				else if (k < 72) c.char_code = CH_LF;
				else if (k < 80) c.char_code = CH_TAB;
				else if (k < 86) c.char_code = CH_BS;
				else if (k < 90) c.char_code = CH_CR;
				else             c.char_code = ignored_byte();
			end
		end
		return c;
	endfunction

	// Offer one item and hold it until taken
	task automatic send_cmd(input tmcw_in_t c);
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		mirror.note_cmd(c);
	endtask

	task automatic idle_cmd(input int n);
		if (n == 0) return;
		@(negedge clk);
		cmd_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Drop valid and wait until every result due has come back
	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attr(input logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		mirror.set_attr(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Result side: check taken items, stall at random, hold off once for long
	initial begin
		int  seen;
		int  hold;
		int  blk;
		bit  burst;
		bit  held_long;
		int  r;
		seen      = 0;
		hold      = 0;
		blk       = 0;
		burst     = 1'b0;
		held_long = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
				mirror.check_result(rsp);
				seen++;
			end
			@(negedge clk);
			blk++;
			if (blk % 64 == 0) burst = ($urandom_range(0, 3) == 0);
			if (seen >= HOLDOFF_AT && !held_long) begin
				held_long = 1'b1;
				hold      = HOLDOFF;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else if (burst) begin
				rsp_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					rsp_stall <= 1'b0;
				end else begin
					if (r < 92)      hold = $urandom_range(0, 2);
					else if (r < 98) hold = $urandom_range(2, 11);
					else             hold = $urandom_range(19, MAX_STALL - 1);
					rsp_stall <= 1'b1;
				end
			end
		end
	end

	// Item side: reset, directed items, then random phases with new attributes
	initial begin
		logic [7:0] attr_plan [N_PHASES];
		bit         burst;
		int         gap;
		mirror = new();
		foreach (attr_plan[i]) attr_plan[i] = 8'($urandom_range(0, 255));
		attr_plan[0] = 8'h00;
		attr_plan[1] = 8'hFF;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_attr(8'($urandom_range(0, 255)));

		// Reset contents, out of range read, every put class, unused action, clear
		send_cmd(make_cmd(ACT_READ, 8'h00, 0));
		send_cmd(make_cmd(ACT_READ, 8'hFF, N_CELLS - 1));
		send_cmd(make_cmd(ACT_READ, 8'h00, IDX_MAX));
		send_cmd(make_cmd(ACT_READ, 8'h00, N_CELLS));
		send_cmd(make_cmd(ACT_PUT, CH_BS, 0));
		send_cmd(make_cmd(ACT_PUT, 8'h20, 0));
		send_cmd(make_cmd(ACT_PUT, 8'h7F, IDX_MAX));
		send_cmd(make_cmd(ACT_PUT, 8'h00, 0));
		send_cmd(make_cmd(ACT_PUT, 8'hFF, 0));
		send_cmd(make_cmd(ACT_PUT, 8'h80, 0));
		send_cmd(make_cmd(ACT_PUT, 8'h1F, 0));
		send_cmd(make_cmd(ACT_PUT, CH_BS, 0));
		send_cmd(make_cmd(ACT_PUT, 8'h41, 0));
		send_cmd(make_cmd(ACT_PUT, CH_TAB, 0));
		send_cmd(make_cmd(ACT_PUT, CH_CR, 0));
		send_cmd(make_cmd(ACT_PUT, CH_LF, 0));
		send_cmd(make_cmd(ACT_NOP, 8'hFF, IDX_MAX));
		send_cmd(make_cmd(ACT_READ, 8'h00, 1));
		send_cmd(make_cmd(ACT_CLEAR, 8'h00, 0));
		send_cmd(make_cmd(ACT_READ, 8'h00, 1));
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			write_attr(attr_plan[p]);
			burst = 1'b0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 64 == 0) burst = ($urandom_range(0, 3) == 0);
				send_cmd(random_cmd(p % 2 == 1));
				gap = burst ? 0 : gap_len();
				idle_cmd(gap);
			end
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
